FILE: hdl/ads_pkg.sv
// ----------------------------------------------------------------------------
// ads_pkg
// Shared types and fixed constants of the Atkinson dither stream.
// ----------------------------------------------------------------------------
package ads_pkg;

	// Fixed field and register widths
	localparam int GREY_W       = 8;
	localparam int WIDTH_REG_W  = 9;
	localparam int HEIGHT_REG_W = 11;
	localparam int ROW_W        = 10;
	localparam int ROW_CMP_W    = 12;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 11;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_HEIGHT = 1'b1;

	// Register reset values
	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 9'd256;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 11'd1;

	// Quantizer and diffusion constants
	localparam int HEIGHT_LIMIT = 1024;
	localparam int THRESHOLD    = 127;
	localparam int WHITE_LEVEL  = 255;
	localparam int SHARE_SHIFT  = 3;

	// Raster position flags of one pixel
	typedef struct packed {
		logic last_col;
		logic last_row;
		logic right1;
		logic right2;
		logic below1;
		logic below2;
	} pos_flags_t;

	// One result beat
	typedef struct packed {
		logic dot_white;
		logic row_end;
		logic frame_end;
	} dot_res_t;

endpackage

FILE: hdl/ads_ram.sv
// ----------------------------------------------------------------------------
// ads_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ads_ram #(
	parameter int WIDTH = 22,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hdl/ads_raster.sv
// ----------------------------------------------------------------------------
// ads_raster
// Raster position counters; gives column and edge flags of the next pixel.
// ----------------------------------------------------------------------------
module ads_raster #(
	parameter int MAX_WIDTH = 256,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                advance,
	input  logic [ads_pkg::WIDTH_REG_W-1:0]     region_width,
	input  logic [ads_pkg::HEIGHT_REG_W-1:0]    region_height,
	output logic [CW-1:0]                       col,
	output ads_pkg::pos_flags_t                 flags
);

	localparam int WCB = ((CW + 1) > ads_pkg::WIDTH_REG_W ?
		(CW + 1) : ads_pkg::WIDTH_REG_W) + 1;
	localparam int RCB = ads_pkg::ROW_CMP_W;
	localparam logic [WCB-1:0] MAX_W = WCB'(MAX_WIDTH);
	localparam logic [RCB-1:0] MAX_H = RCB'(ads_pkg::HEIGHT_LIMIT);

	logic [CW-1:0]               col_q;
	logic [ads_pkg::ROW_W-1:0]   row_q;
	logic [WCB-1:0]              w_ext, w_eff, c_ext, c_eff;
	logic [RCB-1:0]              h_ext, h_eff, r_ext;

	// size clamps
	always_comb begin
		w_ext = WCB'(region_width);
		if (w_ext == '0) begin
			w_eff = WCB'(1);
		end else if (w_ext > MAX_W) begin
			w_eff = MAX_W;
		end else begin
			w_eff = w_ext;
		end
		h_ext = RCB'(region_height);
		if (h_ext == '0) begin
			h_eff = RCB'(1);
		end else if (h_ext > MAX_H) begin
			h_eff = MAX_H;
		end else begin
			h_eff = h_ext;
		end
		c_ext = WCB'(col_q);
		c_eff = (c_ext >= MAX_W) ? (MAX_W - WCB'(1)) : c_ext;
		r_ext = RCB'(row_q);
	end

	// edge flags of the pixel at the current position
	always_comb begin
		flags.last_col = (c_eff + WCB'(1)) >= w_eff;
		flags.right1   = (c_eff + WCB'(1)) <  w_eff;
		flags.right2   = (c_eff + WCB'(2)) <  w_eff;
		flags.last_row = (r_ext + RCB'(1)) >= h_eff;
		flags.below1   = (r_ext + RCB'(1)) <  h_eff;
		flags.below2   = (r_ext + RCB'(2)) <  h_eff;
		col            = CW'(c_eff);
	end

	// position update per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (flags.last_col) begin
				col_q <= '0;
				row_q <= flags.last_row ? '0 : ads_pkg::ROW_W'(r_ext + RCB'(1));
			end else begin
				col_q <= CW'(c_eff + WCB'(1));
			end
		end
	end

endmodule

FILE: hdl/ads_diffuse.sv
// ----------------------------------------------------------------------------
// ads_diffuse
// Quantize stage: merges pending error, thresholds, and spreads error into
// the right-hand registers and the line store (read-modify-write with a held
// entry and a same-cycle bypass).
// ----------------------------------------------------------------------------
module ads_diffuse #(
	parameter int MAX_WIDTH = 256,
	parameter int ERR_BITS  = 11,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int E  = ERR_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             load,
	input  logic                             fire,
	input  logic [ads_pkg::GREY_W-1:0]       grey_level,
	input  logic [CW-1:0]                    col,
	input  ads_pkg::pos_flags_t              flags_in,
	input  logic [2*E-1:0]                   rd_data,
	output logic                             wr_en,
	output logic [CW-1:0]                    wr_addr,
	output logic [2*E-1:0]                   wr_data,
	output ads_pkg::dot_res_t                res
);

	localparam int OW = E + 2;
	localparam logic signed [OW-1:0] THR   = OW'(ads_pkg::THRESHOLD);
	localparam logic signed [OW-1:0] WHITE = OW'(ads_pkg::WHITE_LEVEL);
	localparam logic signed [OW-1:0] RND   = OW'((1 << ads_pkg::SHARE_SHIFT) - 1);

	// stage 1 payload
	logic [ads_pkg::GREY_W-1:0]  grey_s1;
	logic [CW-1:0]               col_s1;
	ads_pkg::pos_flags_t         flags_s1;

	// running error state
	logic signed [E-1:0]  pr1_q, pr2_q, pbr_q;
	logic                 held_valid_q;
	logic [CW-1:0]        held_addr_q;
	logic signed [E-1:0]  held_nre_q, held_sre_q;
	logic                 byp_hit_q;
	logic [2*E-1:0]       byp_data_q;
	logic [CW:0]          fill_q;

	logic                 ent_ok, frame_end;
	logic signed [E-1:0]  cur_nre, cur_sre;
	logic signed [OW-1:0] old_val, diff, diff_adj, err_wide;
	logic signed [E-1:0]  err, new_nre, new_sre, fin_nre;
	logic                 white;

	// load stage 1 and capture a write that races the read
	always_ff @(posedge clk) begin
		if (load) begin
			grey_s1    <= grey_level;
			col_s1     <= col;
			flags_s1   <= flags_in;
			byp_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_hit_q <= 1'b0;
		end else if (load) begin
			byp_hit_q <= wr_en && (wr_addr == col);
		end
	end

	// entry select: held entry, then bypass, then store (beyond fill reads zero)
	always_comb begin
		ent_ok = ((CW+1)'(col_s1) < fill_q);
		if (held_valid_q && (held_addr_q == col_s1)) begin
			cur_nre = held_nre_q;
			cur_sre = held_sre_q;
		end else if (byp_hit_q) begin
			cur_nre = $signed(byp_data_q[2*E-1:E]);
			cur_sre = $signed(byp_data_q[E-1:0]);
		end else if (ent_ok) begin
			cur_nre = $signed(rd_data[2*E-1:E]);
			cur_sre = $signed(rd_data[E-1:0]);
		end else begin
			cur_nre = '0;
			cur_sre = '0;
		end
	end

	// threshold and error share, divide by eight toward zero
	always_comb begin
		old_val  = $signed(OW'({1'b0, grey_s1})) + OW'(pr1_q) + OW'(cur_nre);
		white    = old_val > THR;
		diff     = old_val - (white ? WHITE : '0);
		diff_adj = diff[OW-1] ? (diff + RND) : diff;
		err_wide = diff_adj >>> ads_pkg::SHARE_SHIFT;
		err      = $signed(err_wide[E-1:0]);
		new_nre  = flags_s1.below1 ? (cur_sre + pbr_q + err) : '0;
		new_sre  = flags_s1.below2 ? err : '0;
		fin_nre  = held_nre_q + (flags_s1.below1 ? err : '0);
	end

	// write port: finish left neighbor, or flush the entry held over a row end
	always_comb begin
		frame_end = flags_s1.last_col && flags_s1.last_row;
		if (col_s1 != '0) begin
			wr_addr = col_s1 - CW'(1);
			wr_data = {fin_nre, held_sre_q};
			wr_en   = fire && !frame_end;
		end else begin
			wr_addr = held_addr_q;
			wr_data = {held_nre_q, held_sre_q};
			wr_en   = fire && !frame_end && held_valid_q;
		end
	end

	always_comb begin
		res.dot_white = white;
		res.row_end   = flags_s1.last_col;
		res.frame_end = frame_end;
	end

	// error state update per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pr1_q        <= '0;
			pr2_q        <= '0;
			pbr_q        <= '0;
			held_valid_q <= 1'b0;
			held_addr_q  <= '0;
			held_nre_q   <= '0;
			held_sre_q   <= '0;
			fill_q       <= '0;
		end else if (fire) begin
			pr1_q <= flags_s1.right1 ? (pr2_q + err) : '0;
			pr2_q <= flags_s1.right2 ? err : '0;
			pbr_q <= flags_s1.right1 ? err : '0;
			if (frame_end) begin
				held_valid_q <= 1'b0;
				fill_q       <= '0;
			end else begin
				held_valid_q <= 1'b1;
				held_addr_q  <= col_s1;
				held_nre_q   <= new_nre;
				held_sre_q   <= new_sre;
				if (wr_en && (((CW+1)'(wr_addr) + (CW+1)'(1)) > fill_q)) begin
					fill_q <= (CW+1)'(wr_addr) + (CW+1)'(1);
				end
			end
		end
	end

	// mid-row pixel always finds its left neighbor held
	a_held_chain: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (col_s1 != '0) |-> held_valid_q && (held_addr_q == col_s1 - CW'(1)))
		else $error("left neighbor entry not held");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (CW+1)'(MAX_WIDTH))
		else $error("fill count beyond line store depth");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fire && frame_end |=> (fill_q == '0) && !held_valid_q)
		else $error("error state not cleared at frame end");

endmodule

FILE: hdl/atkinson_dither_stream.sv
// ----------------------------------------------------------------------------
// atkinson_dither_stream
// Atkinson error-diffusion dither: grey pixels in raster order in, one
// black/white dot per pixel out, error kept in one line store RAM.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------
//  cfg      | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//  in       | in        | in_valid/in_ready   | grey_level
//  out      | out       | out_valid/out_ready | dot_white, row_end, frame_end
//
//  One pixel per clock sustained while the output is taken; the line store is
//  read when a beat is accepted and written back as the next beat fires; a held
//  entry and a bypass register cover reads that overlap pending writes.
//  Path: an accepted beat enters stage 1; its dot is registered when it fires.
//  Reset: no clearing pass; a fill count marks stale line store entries as zero.
//  Stalls: the output register lets the next pixel enter while a dot waits.
// ----------------------------------------------------------------------------
module atkinson_dither_stream #(
	parameter int MAX_WIDTH = 256,
	parameter int ERR_BITS  = 11
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ads_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ads_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ads_pkg::GREY_W-1:0]          grey_level,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                dot_white,
	output logic                                row_end,
	output logic                                frame_end
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic [ads_pkg::WIDTH_REG_W-1:0]   width_q;
	logic [ads_pkg::HEIGHT_REG_W-1:0]  height_q;
	logic                              valid_s1, out_valid_q;
	ads_pkg::dot_res_t                 out_q, res;
	logic                              accept, fire;
	logic [CW-1:0]                     col;
	ads_pkg::pos_flags_t               flags;
	logic                              wr_en;
	logic [CW-1:0]                     wr_addr;
	logic [2*ERR_BITS-1:0]             wr_data, rd_data;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ads_pkg::WIDTH_RESET;
			height_q <= ads_pkg::HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ads_pkg::REG_REGION_WIDTH: begin
					width_q <= cfg_data[ads_pkg::WIDTH_REG_W-1:0];
				end
				ads_pkg::REG_REGION_HEIGHT: begin
					height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// pipeline handshake
	assign fire     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !fire);
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign dot_white = out_q.dot_white;
	assign row_end   = out_q.row_end;
	assign frame_end = out_q.frame_end;

	ads_raster #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_raster (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (accept),
		.region_width  (width_q),
		.region_height (height_q),
		.col           (col),
		.flags         (flags)
	);

	// line store: {next row error, second row error} per column
	ads_ram #(
		.WIDTH (2 * ERR_BITS),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (accept),
		.raddr (col),
		.rdata (rd_data)
	);

	ads_diffuse #(
		.MAX_WIDTH (MAX_WIDTH),
		.ERR_BITS  (ERR_BITS)
	) u_diffuse (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (accept),
		.fire       (fire),
		.grey_level (grey_level),
		.col        (col),
		.flags_in   (flags),
		.rd_data    (rd_data),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.res        (res)
	);

	a_open_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input blocked with empty output register");

	a_frame_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.frame_end |-> out_q.row_end)
		else $error("frame end without row end");

	a_fire_fills: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("fired beat missing at output");

endmodule
